FILE: hw/rtl/bff_pkg.sv
// ----------------------------------------------------------------------------
// bff_pkg
// Shared types, codes and sizes of the byte fifo packet framer.
// ----------------------------------------------------------------------------
package bff_pkg;

	// ring and packet sizes
	localparam int TX_DEPTH      = 128;
	localparam int RX_DEPTH      = 64;
	localparam int PAYLOAD_BYTES = 63;
	localparam int TX_AW         = $clog2(TX_DEPTH);
	localparam int RX_AW         = $clog2(RX_DEPTH);
	localparam int LEN_W         = $clog2(PAYLOAD_BYTES + 1);
	localparam int PAY_W         = PAYLOAD_BYTES * 8;

	// header marks
	localparam logic [7:0] HDR_PACKET = 8'h80;
	localparam logic [7:0] HDR_LAST   = 8'h40;

	typedef enum logic [1:0] {
		ACT_WRITE  = 2'd0,
		ACT_COMMIT = 2'd1,
		ACT_RECV   = 2'd2,
		ACT_READ   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		KIND_PACKET   = 3'd0,
		KIND_WR_OK    = 3'd1,
		KIND_WR_DROP  = 3'd2,
		KIND_RD_DATA  = 3'd3,
		KIND_RD_EMPTY = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_RECV,
		ST_DRAIN,
		ST_PACKET,
		ST_RD_REQ,
		ST_RD_DATA
	} state_t;

	typedef struct packed {
		action_t     action;
		logic [7:0]  data_byte;
		logic [7:0]  rx_header;
		logic [63:0] rx_payload0;
		logic [63:0] rx_payload1;
		logic [63:0] rx_payload2;
		logic [63:0] rx_payload3;
		logic [63:0] rx_payload4;
		logic [63:0] rx_payload5;
		logic [63:0] rx_payload6;
		logic [55:0] rx_payload7;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  tx_header;
		logic [63:0] tx_payload0;
		logic [63:0] tx_payload1;
		logic [63:0] tx_payload2;
		logic [63:0] tx_payload3;
		logic [63:0] tx_payload4;
		logic [63:0] tx_payload5;
		logic [63:0] tx_payload6;
		logic [55:0] tx_payload7;
		logic [7:0]  read_value;
		logic        last;
	} out_item_t;

endpackage

FILE: hw/rtl/bff_ifs.sv
// ----------------------------------------------------------------------------
// bff_ifs
// Valid/ready channels of the framer: request in, result out.
// ----------------------------------------------------------------------------
interface bff_in_if import bff_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface bff_out_if import bff_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/bff_ram.sv
// ----------------------------------------------------------------------------
// bff_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bff_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/byte_fifo_packet_framer_core.sv
// ----------------------------------------------------------------------------
// byte_fifo_packet_framer_core
// Byte rings between a host and a 64-byte packet link: writes fill the
// transmit ring, a commit drains it into packets, received packets fill the
// receive ring, reads pop it.
//
//   channel | dir | payload     | transfer
//   --------+-----+-------------+----------------------------------
//   req     | in  | in_item_t   | valid & ready at a rising edge
//   rsp     | out | out_item_t  | valid & ready at a rising edge
//
// One request at a time; ready is high only while the sequencer is idle.
// Receive: one ring byte per cycle.
// Commit: packet by packet, one transmit ring read per cycle.
// Read: drains the transmit ring as a commit does, then reads the receive ring.
// Reset clears pointers and control only; ring contents are never cleared.
// A held result stalls the sequencer only when the next result is due.
// ----------------------------------------------------------------------------
module byte_fifo_packet_framer_core import bff_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	bff_in_if.sink   req,
	bff_out_if.source rsp
);

	// wrap-around pointer steps
	function automatic logic [TX_AW-1:0] tx_next(input logic [TX_AW-1:0] p);
		return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : TX_AW'(p + 1'b1);
	endfunction

	function automatic logic [RX_AW-1:0] rx_next(input logic [RX_AW-1:0] p);
		return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : RX_AW'(p + 1'b1);
	endfunction

	state_t state_q, state_d;

	// ring pointers
	logic [TX_AW-1:0] tx_head_q, tx_tail_q;
	logic [RX_AW-1:0] rx_head_q, rx_tail_q;

	// latched request
	logic             read_q;
	logic [7:0]       data_q;
	logic [LEN_W-1:0] cnt_q;
	logic [LEN_W-1:0] idx_q;
	logic [PAY_W-1:0] rxb_q;

	// packet assembly
	logic [LEN_W-1:0]                len_q;
	logic                            vld_s1;
	logic [LEN_W-1:0]                idx_s1;
	logic [PAYLOAD_BYTES-1:0][7:0]   pkt_q;

	// result register
	logic      out_valid_q;
	out_item_t out_q;
	out_item_t res_d;

	// ram ports
	logic             tx_we, tx_re, rx_we, rx_re;
	logic [7:0]       tx_rdata, rx_rdata;

	// control strobes
	logic accept, can_load, load;
	logic tx_empty, tx_full, rx_empty, rx_full, drain_go, recv_done;
	logic issue, recv_step, rx_pop, rx_clr, pkt_clr;

	assign accept    = req.valid && req.ready;
	assign can_load  = !out_valid_q || rsp.ready;
	assign tx_empty  = (tx_head_q == tx_tail_q);
	assign tx_full   = (tx_head_q == tx_next(tx_tail_q));
	assign rx_empty  = (rx_head_q == rx_tail_q);
	assign rx_full   = (rx_head_q == rx_next(rx_tail_q));
	assign drain_go  = !tx_empty && (len_q != LEN_W'(PAYLOAD_BYTES));
	assign recv_done = (idx_q == cnt_q) || rx_full;

	assign req.ready   = (state_q == ST_IDLE);
	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	// transmit ring
	bff_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_tail_q),
		.wdata (data_q),
		.re    (tx_re),
		.raddr (tx_head_q),
		.rdata (tx_rdata)
	);

	// receive ring
	bff_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_tail_q),
		.wdata (rxb_q[7:0]),
		.re    (rx_re),
		.raddr (rx_head_q),
		.rdata (rx_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req.payload.action)
						ACT_WRITE:  state_d = ST_WRITE;
						ACT_COMMIT: state_d = tx_empty ? ST_IDLE : ST_DRAIN;
						ACT_RECV:   state_d = ST_RECV;
						ACT_READ:   state_d = tx_empty ? ST_RD_REQ : ST_DRAIN;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_WRITE: begin
				if (can_load) state_d = ST_IDLE;
			end
			ST_RECV: begin
				if (recv_done) state_d = ST_IDLE;
			end
			ST_DRAIN: begin
				if (!drain_go) state_d = ST_PACKET;
			end
			ST_PACKET: begin
				if (can_load) begin
					if (!tx_empty) state_d = ST_DRAIN;
					else state_d = read_q ? ST_RD_REQ : ST_IDLE;
				end
			end
			ST_RD_REQ: begin
				if (!rx_empty) state_d = ST_RD_DATA;
				else if (can_load) state_d = ST_IDLE;
			end
			ST_RD_DATA: begin
				if (can_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		tx_we     = 1'b0;
		tx_re     = 1'b0;
		rx_we     = 1'b0;
		rx_re     = 1'b0;
		load      = 1'b0;
		issue     = 1'b0;
		recv_step = 1'b0;
		rx_pop    = 1'b0;
		rx_clr    = 1'b0;
		pkt_clr   = accept;
		res_d     = '0;
		unique case (state_q)
			ST_IDLE: ;
			ST_WRITE: begin
				if (can_load) begin
					load       = 1'b1;
					res_d.kind = tx_full ? KIND_WR_DROP : KIND_WR_OK;
					res_d.last = 1'b1;
					tx_we      = !tx_full;
				end
			end
			ST_RECV: begin
				if (!recv_done) begin
					rx_we     = 1'b1;
					recv_step = 1'b1;
				end
			end
			ST_DRAIN: begin
				if (drain_go) begin
					tx_re = 1'b1;
					issue = 1'b1;
				end
			end
			ST_PACKET: begin
				if (can_load) begin
					load              = 1'b1;
					rx_clr            = 1'b1;
					pkt_clr           = 1'b1;
					res_d.kind        = KIND_PACKET;
					res_d.tx_header   = HDR_PACKET | (tx_empty ? HDR_LAST : 8'h00)
						| 8'(len_q);
					res_d.tx_payload0 = pkt_q[7:0];
					res_d.tx_payload1 = pkt_q[15:8];
					res_d.tx_payload2 = pkt_q[23:16];
					res_d.tx_payload3 = pkt_q[31:24];
					res_d.tx_payload4 = pkt_q[39:32];
					res_d.tx_payload5 = pkt_q[47:40];
					res_d.tx_payload6 = pkt_q[55:48];
					res_d.tx_payload7 = pkt_q[62:56];
					res_d.last        = tx_empty && !read_q;
				end
			end
			ST_RD_REQ: begin
				if (!rx_empty) begin
					rx_re = 1'b1;
				end else if (can_load) begin
					load       = 1'b1;
					res_d.kind = KIND_RD_EMPTY;
					res_d.last = 1'b1;
				end
			end
			ST_RD_DATA: begin
				if (can_load) begin
					load             = 1'b1;
					rx_pop           = 1'b1;
					res_d.kind       = KIND_RD_DATA;
					res_d.read_value = rx_rdata;
					res_d.last       = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tx_head_q   <= '0;
			tx_tail_q   <= '0;
			rx_head_q   <= '0;
			rx_tail_q   <= '0;
			read_q      <= 1'b0;
			idx_q       <= '0;
			len_q       <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			if (accept) begin
				read_q <= (req.payload.action == ACT_READ);
				idx_q  <= '0;
			end
			if (tx_we) tx_tail_q <= tx_next(tx_tail_q);
			if (issue) begin
				tx_head_q <= tx_next(tx_head_q);
				len_q     <= LEN_W'(len_q + 1'b1);
			end else if (pkt_clr) begin
				len_q <= '0;
			end
			// receive ring: clear after each sent packet, else push and pop
			if (rx_clr) begin
				rx_head_q <= '0;
				rx_tail_q <= '0;
			end else begin
				if (recv_step) begin
					rx_tail_q <= rx_next(rx_tail_q);
					idx_q     <= LEN_W'(idx_q + 1'b1);
				end
				if (rx_pop) rx_head_q <= rx_next(rx_head_q);
			end
			// result register
			if (load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= req.payload.data_byte;
			cnt_q  <= req.payload.rx_header[LEN_W-1:0];
			rxb_q  <= {req.payload.rx_payload7, req.payload.rx_payload6,
				req.payload.rx_payload5, req.payload.rx_payload4,
				req.payload.rx_payload3, req.payload.rx_payload2,
				req.payload.rx_payload1, req.payload.rx_payload0};
		end else if (recv_step) begin
			rxb_q <= rxb_q >> 8;
		end
		if (issue) idx_s1 <= len_q;
		// packet buffer: clear per packet, capture ring data in the cycle after the read
		if (pkt_clr) pkt_q <= '0;
		else if (vld_s1) pkt_q[idx_s1] <= tx_rdata;
		if (load) out_q <= res_d;
	end

endmodule
